/* design/backslash_escape_decoder_unit_macros.svh */
// Assertion macros of the backslash escape decoder, used by its datapath.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define BSED_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion violated");
// Next-cycle implication, disabled during reset.
`define BSED_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion violated");
`else
`define BSED_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define BSED_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

/* design/bsed_pkg.sv */
// Shared types and constants of the backslash escape decoder.
// No dependencies; imported by the controller, the datapath and the top level.
package bsed_pkg;

   // Window geometry.
   localparam int WIN_DEPTH = 6;
   localparam int CNT_W     = 3;

   // Character codes used by the escape parser.
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_U         = 8'h75;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic append;   // write the accepted request byte into the window
      logic emit;     // load the selected decoded byte into the output register
      logic advance;  // move to the next byte of the current resolution
      logic shift;    // drop the consumed bytes from the window head
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       stall;       // window empty or escape needs more bytes
      logic [1:0] num;         // decoded bytes of the current resolution
      logic       idx_last;    // selected byte is the last one of the resolution
      logic       rest_empty;  // window is empty once this resolution is consumed
      logic       out_free;    // output register can take a byte this cycle
   } status_type;

endpackage

/* design/bsed_datapath.sv */
// Datapath of the backslash escape decoder: window, escape parser and output register.
// Depends on bsed_pkg and the assertion macros header.
`include "backslash_escape_decoder_unit_macros.svh"

module bsed_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bsed_pkg::cmd_type    cmd,
   output bsed_pkg::status_type status,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 csr_write,
   input  logic                 csr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import bsed_pkg::*;

   logic [7:0]       window_ff [WIN_DEPTH];
   logic [7:0]       window_in [WIN_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fin_ff, fin_in;
   logic             dq_ff, dq_in;
   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             res_ok;
   logic [2:0]       res_k;
   logic [1:0]       res_num;
   logic [7:0]       res_b [3];

   logic [7:0]       w0, w1, w2, w3;
   logic [7:0]       d1, d2, d3;
   logic [15:0]      h2, h3, h4, h5, uval;
   logic             dig2, dig3;
   logic [1:0]       kd;
   logic             named_ok;
   logic [7:0]       named_val;
   logic             out_free;
   logic             idx_last;
   logic             rest_empty;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // Digit value kept to 16 bits; letters outside a-f wrap like the unsigned original.
   function automatic logic [15:0] hex_val16(input logic [7:0] c);
      logic [15:0] l;
      l = {8'h00, c};
      if (is_dec(c)) begin
         return l - 16'h0030;
      end
      if ((c >= 8'h41) && (c <= 8'h5A)) begin
         l = l + 16'h0020;
      end
      return l - 16'h0057;
   endfunction

   assign w0 = window_ff[0];
   assign w1 = window_ff[1];
   assign w2 = window_ff[2];
   assign w3 = window_ff[3];
   assign d1 = w1 - 8'h30;
   assign d2 = w2 - 8'h30;
   assign d3 = w3 - 8'h30;
   assign h2 = hex_val16(w2);
   assign h3 = hex_val16(w3);
   assign h4 = hex_val16(window_ff[4]);
   assign h5 = hex_val16(window_ff[5]);
   assign uval = (h2 << 12) + (h3 << 8) + (h4 << 4) + h5;

   // Decimal digits following the backslash and its first digit.
   assign dig2 = (count_ff > 3'd2) && is_dec(w2);
   assign dig3 = dig2 && (count_ff > 3'd3) && is_dec(w3);
   assign kd   = dig3 ? 2'd3 : (dig2 ? 2'd2 : 2'd1);

   // Named escapes.
   always_comb begin
      named_ok  = 1'b1;
      named_val = 8'h00;
      case (w1)
         8'h61:        named_val = 8'd7;
         8'h62:        named_val = 8'd8;
         8'h65:        named_val = 8'd27;
         8'h66:        named_val = 8'd12;
         8'h6E:        named_val = 8'd10;
         8'h72:        named_val = 8'd13;
         8'h73:        named_val = 8'd32;
         8'h74:        named_val = 8'd9;
         8'h76:        named_val = 8'd11;
         CH_DQUOTE:    named_val = 8'd34;
         CH_SQUOTE:    named_val = 8'd39;
         CH_BACKSLASH: named_val = 8'd92;
         default:      named_ok  = 1'b0;
      endcase
   end

   // Resolve the head of the window: bytes consumed and bytes released.
   always_comb begin
      res_ok   = 1'b1;
      res_k    = 3'd1;
      res_num  = 2'd0;
      res_b[0] = w0;
      res_b[1] = 8'h00;
      res_b[2] = 8'h00;
      if (count_ff == '0) begin
         res_ok = 1'b0;
      end else if (w0 != CH_BACKSLASH) begin
         res_num = 2'd1;
      end else if (count_ff < 3'd2) begin
         res_ok  = fin_ff;
         res_num = 2'd1;
      end else if (!dq_ff) begin
         res_num = 2'd1;
         if ((w1 == CH_SQUOTE) || (w1 == CH_BACKSLASH)) begin
            res_k    = 3'd2;
            res_b[0] = w1;
         end
      end else if (is_dec(w1)) begin
         res_num = 2'd1;
         res_k   = {1'b0, kd} + 3'd1;
         if ((kd != 2'd3) && (({1'b0, kd} + 3'd1) >= count_ff) && !fin_ff) begin
            res_ok = 1'b0;
         end
         case (kd)
            2'd1:    res_b[0] = d1;
            2'd2:    res_b[0] = 8'((d1 << 3) + d2);
            default: res_b[0] = 8'((d1 << 6) + (d2 << 3) + d3);
         endcase
      end else if (w1 == CH_X) begin
         if (count_ff >= 3'd4) begin
            res_num = 2'd1;
            if (is_hex(w3)) begin
               res_k    = 3'd4;
               res_b[0] = 8'((h2 << 4) + h3);
            end else begin
               res_k    = 3'd3;
               res_b[0] = h2[7:0];
            end
         end else begin
            res_ok = fin_ff;
         end
      end else if (w1 == CH_U) begin
         if (count_ff >= 3'd6) begin
            res_k = 3'd6;
            if (uval <= 16'h007F) begin
               res_num  = 2'd1;
               res_b[0] = uval[7:0];
            end else if (uval <= 16'h07FF) begin
               res_num  = 2'd2;
               res_b[0] = {3'b110, uval[10:6]};
               res_b[1] = {2'b10, uval[5:0]};
            end else begin
               res_num  = 2'd3;
               res_b[0] = {4'b1110, uval[15:12]};
               res_b[1] = {2'b10, uval[11:6]};
               res_b[2] = {2'b10, uval[5:0]};
            end
         end else begin
            res_ok = fin_ff;
         end
      end else if (named_ok) begin
         res_num  = 2'd1;
         res_k    = 3'd2;
         res_b[0] = named_val;
      end
   end

   // Status toward the controller.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_last   = (idx_ff == 2'(res_num - 2'd1));
   assign rest_empty = (count_ff == res_k);
   assign status.stall      = !res_ok;
   assign status.num        = res_num;
   assign status.idx_last   = idx_last;
   assign status.rest_empty = rest_empty;
   assign status.out_free   = out_free;

   // Window update: append a request byte or drop the consumed head.
   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      fin_in    = fin_ff;
      if (cmd.append) begin
         window_in[count_ff] = req_tdata;
         count_in            = count_ff + 3'd1;
         fin_in              = req_tlast;
      end else if (cmd.shift) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            for (int s = 1; s <= WIN_DEPTH; s++) begin
               if ((res_k == 3'(s)) && (i + s < WIN_DEPTH)) begin
                  window_in[i] = window_ff[(i + s) % WIN_DEPTH];
               end
            end
         end
         count_in = count_ff - res_k;
      end
   end

   // Byte index within the current resolution.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.shift) begin
         idx_in = 2'd0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // Output register, also holding a finished byte while the next request enters.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_b[idx_ff];
         rsp_last_in  = fin_ff && idx_last && rest_empty;
      end
   end

   // Mode register.
   assign dq_in = csr_write ? csr_data : dq_ff;

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         dq_ff        <= 1'b1;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         dq_ff        <= dq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Consistency checks.
   `BSED_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= 3'(WIN_DEPTH))
   `BSED_ASSERT_IMPLY(a_append_room, clock, reset, cmd.append, count_ff < 3'(WIN_DEPTH))
   `BSED_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, out_free)
   `BSED_ASSERT_NEXT(a_drain_empty, clock, reset, cmd.shift && rest_empty, count_ff == '0)

endmodule

/* design/bsed_controller.sv */
// Controller of the backslash escape decoder: accepts requests and sequences resolutions.
// Depends on bsed_pkg.
module bsed_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bsed_pkg::status_type status,
   output bsed_pkg::cmd_type    cmd
);
   import bsed_pkg::*;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.append = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.stall) begin
               state_in = ST_IDLE;
            end else if (status.num == 2'd0) begin
               // Dropped backslash: consume without output.
               cmd.shift = 1'b1;
               if (status.rest_empty) begin
                  state_in = ST_IDLE;
               end
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.idx_last) begin
                  cmd.shift = 1'b1;
                  if (status.rest_empty) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/backslash_escape_decoder_unit.sv */
// A request is written into the window in the idle state; in the scan state that follows,
// its first output byte is loaded into the output register once that register is free.
// A plain byte is appended, then emitted. A byte that an escape holds is appended, then the
// scan finds the escape open. A resolution takes one cycle per output byte while the
// one-byte output register is free, and emits nothing when it only drops a backslash. Reset
// (synchronous, active high) empties the window and the output register and selects double-quote mode.
module backslash_escape_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_last
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // double_quote_mode
);
   import bsed_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The mode register takes a write in any cycle.
   assign csr_ready = 1'b1;

   bsed_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bsed_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_write  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/backslash_escape_decoder_unit_test.sv */
// Self-checking testbench for the backslash escape decoder unit: directed strings, then
// random strings in both quote modes under four handshake pacing phases.
// Depends on bsed_pkg and backslash_escape_decoder_unit.
module backslash_escape_decoder_unit_test;
   import bsed_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 32;
   localparam int END_WAIT_LIMIT = 20000;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_DECODED    = 6;
   localparam int ITEMS_PER_HALF = 38;
   localparam int PRINT_LIMIT    = 30;
   localparam string NAMED_SET   = "abefnrstv\"'\\";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_byte_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       req_tlast;   // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;   // out_last
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_data;    // double_quote_mode

   // Decoder state as the block should hold it.
   logic [7:0]       win_bytes [WIN_DEPTH];
   int               win_count;
   logic             dq_mode;
   logic [7:0]       step_bytes [$];
   decoded_byte_type expected_bytes [$];
   logic [7:0]       text_bytes [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int items_sent     = 0;
   int strings_sent   = 0;
   int bytes_checked  = 0;
   int mode_writes    = 0;

   backslash_escape_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard limit on the run, far above the slowest correct run.
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("timeout with %0d decoded bytes still expected", expected_bytes.size());
      $display("backslash_escape_decoder_unit test failed");
      $finish;
   end

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_hex_digit(logic [7:0] c);
      return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   // Value of one hex position; a non-hex byte still yields lowercase(c) - 'a' + 10.
   function automatic logic [15:0] nibble_value(logic [7:0] c);
      logic [15:0] l;
      l = {8'h00, c};
      if (is_digit(c)) return l - 16'h0030;
      if (c >= "A" && c <= "Z") l = l + 16'h0020;
      return l - 16'h0061 + 16'd10;
   endfunction

   function automatic int named_code(logic [7:0] c);
      case (c)
         "a":  return 7;
         "b":  return 8;
         "e":  return 27;
         "f":  return 12;
         "n":  return 10;
         "r":  return 13;
         "s":  return 32;
         "t":  return 9;
         "v":  return 11;
         "\"": return 34;
         "'":  return 39;
         "\\": return 92;
         default: return -1;
      endcase
   endfunction

   // Resolves the escape at the window head; returns the bytes consumed, 0 to wait.
   function automatic int decode_head(bit fin);
      int          n;
      int          k;
      int          m;
      logic [7:0]  v8;
      logic [15:0] v16;
      n = win_count;
      if (win_bytes[0] != CH_BACKSLASH) begin
         step_bytes.push_back(win_bytes[0]);
         return 1;
      end
      if (n < 2) begin
         if (!fin) return 0;
         step_bytes.push_back(win_bytes[0]);
         return 1;
      end
      if (!dq_mode) begin
         if (win_bytes[1] == CH_SQUOTE || win_bytes[1] == CH_BACKSLASH) begin
            step_bytes.push_back(win_bytes[1]);
            return 2;
         end
         step_bytes.push_back(win_bytes[0]);
         return 1;
      end
      if (is_digit(win_bytes[1])) begin
         k = 1;
         while (k < 3 && 1 + k < n && is_digit(win_bytes[1 + k])) k++;
         if (k < 3 && 1 + k >= n && !fin) return 0;
         v8 = 8'h00;
         for (int i = 0; i < k; i++) v8 = v8 * 8'd8 + (win_bytes[1 + i] - "0");
         step_bytes.push_back(v8);
         return k + 1;
      end
      if (win_bytes[1] == CH_X) begin
         if (n >= 4) begin
            k = is_hex_digit(win_bytes[3]) ? 2 : 1;
            v16 = 16'h0000;
            for (int i = 0; i < k; i++) v16 = v16 * 16'd16 + nibble_value(win_bytes[2 + i]);
            step_bytes.push_back(v16[7:0]);
            return k + 2;
         end
         if (!fin) return 0;
         return 1;
      end
      if (win_bytes[1] == CH_U) begin
         if (n >= 6) begin
            v16 = 16'h0000;
            for (int i = 0; i < 4; i++) v16 = v16 * 16'd16 + nibble_value(win_bytes[2 + i]);
            // Code point to UTF-8.
            if (v16 <= 16'h007F) begin
               step_bytes.push_back(v16[7:0]);
            end else if (v16 <= 16'h07FF) begin
               step_bytes.push_back({3'b110, v16[10:6]});
               step_bytes.push_back({2'b10, v16[5:0]});
            end else begin
               step_bytes.push_back({4'b1110, v16[15:12]});
               step_bytes.push_back({2'b10, v16[11:6]});
               step_bytes.push_back({2'b10, v16[5:0]});
            end
            return 6;
         end
         if (!fin) return 0;
         return 1;
      end
      m = named_code(win_bytes[1]);
      if (m >= 0) begin
         step_bytes.push_back(m[7:0]);
         return 2;
      end
      // Unknown escape: the backslash goes, the next byte is scanned again.
      return 1;
   endfunction

   // Appends one accepted request byte and queues the decoded bytes it releases.
   function automatic void predict_request(logic [7:0] b, logic last);
      int k;
      int n;
      if (win_count >= WIN_DEPTH) win_count = WIN_DEPTH - 1;
      win_bytes[win_count] = b;
      win_count++;
      step_bytes.delete();
      while (win_count > 0 && step_bytes.size() <= MAX_DECODED) begin
         k = decode_head(last);
         if (k == 0) break;
         if (k > win_count) k = win_count;
         for (int i = 0; i + k < win_count; i++) win_bytes[i] = win_bytes[i + k];
         win_count -= k;
      end
      if (last) win_count = 0;
      n = (step_bytes.size() > MAX_DECODED) ? MAX_DECODED : step_bytes.size();
      for (int r = 0; r < n; r++) begin
         expected_bytes.push_back('{data: step_bytes[r], last: last && (r == n - 1)});
      end
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got_data, logic got_last,
                                  decoded_byte_type want);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s: got %h last %b, expected %h last %b", $realtime, what,
                  got_data, got_last, want.data, want.last);
      end
      error_count++;
   endtask

   // Receiver pacing.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compares every accepted decoded byte with the oldest expected one.
   always @(posedge clock) begin
      decoded_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("decoded byte with none expected", rsp_tdata, rsp_tlast, '0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               report_mismatch("out_byte", rsp_tdata, rsp_tlast, want);
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch("out_last", rsp_tdata, rsp_tlast, want);
            end
            bytes_checked++;
         end
      end
   end

   // Sends one request byte, with random idle cycles ahead of it.
   task automatic send_byte(logic [7:0] b, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_request(b, last);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
      strings_sent++;
   endtask

   // Stops sending, waits for all expected bytes and lets the window settle.
   task automatic wait_until_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (expected_bytes.size() != 0) begin
         report_mismatch("expected byte never arrived", 8'h00, 1'b0,
                         expected_bytes.pop_front());
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      wait_until_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      dq_mode = mode;
      mode_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hex digit in random case, now and then replaced by an arbitrary byte.
   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if ($urandom_range(7) == 0) return 8'($urandom_range(255));
      if (nib < 10) return "0" + nib;
      return ($urandom_range(1) ? "a" : "A") + nib - 4'd10;
   endfunction

   // Builds and sends one random string: plain bytes, well-formed escapes and cut or unknown ones.
   task automatic build_random_text();
      int          segs;
      logic [15:0] cp;
      text_bytes.delete();
      segs = $urandom_range(1, 5);
      repeat (segs) begin
         case ($urandom_range(11))
            0, 1: text_bytes.push_back(8'($urandom_range(255)));
            2:    text_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
            3: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(NAMED_SET[$urandom_range(NAMED_SET.len() - 1)]);
            end
            4: begin
               text_bytes.push_back(CH_BACKSLASH);
               repeat ($urandom_range(1, 3)) text_bytes.push_back(8'("0" + $urandom_range(9)));
            end
            5: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(CH_X);
               repeat ($urandom_range(1, 2)) begin
                  text_bytes.push_back(hex_char(4'($urandom_range(15))));
               end
            end
            6, 7: begin
               // Code points from each UTF-8 length class.
               case ($urandom_range(2))
                  0:       cp = 16'($urandom_range(16'h007F));
                  1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
                  default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
               endcase
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(CH_U);
               for (int i = 3; i >= 0; i--) text_bytes.push_back(hex_char(cp[i * 4 +: 4]));
            end
            8: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(8'($urandom_range(255)));
            end
            9: begin
               // Hex or unicode escape with at most two digits.
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back($urandom_range(1) ? CH_X : CH_U);
               repeat ($urandom_range(2)) begin
                  text_bytes.push_back(hex_char(4'($urandom_range(15))));
               end
            end
            10: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back($urandom_range(1) ? CH_SQUOTE : CH_BACKSLASH);
            end
            default: text_bytes.push_back(CH_BACKSLASH);
         endcase
      end
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      strings_sent++;
   endtask

   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      strings_sent++;
   endtask

   // A named escape, then a hex escape with no digits left at the string end.
   task automatic test_named_and_cut_hex();
      send_text("\\t\\x");
   endtask

   // Three digit escape using 9, followed by a plain digit.
   task automatic test_digit_escape();
      send_text("\\1299");
   endtask

   // Hex escape whose second position is not a hex digit, then a one digit escape at the end.
   task automatic test_hex_escape();
      send_text("\\x4g\\7");
   endtask

   task automatic test_unicode_escape();
      send_text("\\u20AC");
   endtask

   // Unknown escape, then a backslash as the final byte.
   task automatic test_unknown_and_lone_backslash();
      send_text("\\q\\");
   endtask

   task automatic test_single_quote_rules();
      write_mode(1'b0);
      send_text("\\'\\n");
   endtask

   // A backslash is held under single-quote rules and resolved under double-quote rules.
   task automatic test_mode_change_mid_string();
      send_byte(CH_BACKSLASH, 1'b0);
      write_mode(1'b1);
      send_byte("n", 1'b1);
      strings_sent++;
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, logic first_mode);
      int start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int half = 0; half < 2; half++) begin
         write_mode(half == 0 ? first_mode : ~first_mode);
         start = items_sent;
         while (items_sent - start < ITEMS_PER_HALF) build_random_text();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      win_count  = 0;
      dq_mode    = 1'b1;
      foreach (win_bytes[i]) win_bytes[i] = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_byte_extremes();
      test_named_and_cut_hex();
      test_digit_escape();
      test_hex_escape();
      test_unicode_escape();
      test_unknown_and_lone_backslash();
      test_single_quote_rules();
      test_mode_change_mid_string();

      test_random_traffic(0, 0, 1'b1);
      test_random_traffic(57, 0, 1'b0);
      test_random_traffic(0, 57, 1'b1);
      test_random_traffic(27, 27, 1'b0);

      wait_until_drained();
      $display("Sent %0d request bytes in %0d strings, checked %0d decoded bytes.",
               items_sent, strings_sent, bytes_checked);
      $display("Both quote modes over %0d mode writes, four sender/receiver pacing phases.",
               mode_writes);
      if (error_count == 0) begin
         $display("backslash_escape_decoder_unit test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("backslash_escape_decoder_unit test failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/bsed_pkg.sv
design/bsed_datapath.sv
design/bsed_controller.sv
design/backslash_escape_decoder_unit.sv
tb/backslash_escape_decoder_unit_test.sv
